### rtl/sdiv_pkg.sv
// Shared widths, constants and the per-stage record of the signed divider pipeline.
// No dependencies; every other file uses this package.
`default_nettype none

package sdiv_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned LATENCY = WIDTH + 2;

  localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    word_t rem;
    word_t num;
    word_t den;
    word_t quo;
    logic  neg;
    logic  dz;
  } sdiv_stage_t;

endpackage

`default_nettype wire

### rtl/sdiv_ifs.sv
// Valid/ready channel interfaces for the operand pair and the quotient.
// Depends on sdiv_pkg for the data width.
`default_nettype none

interface sdiv_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdiv_pkg::WIDTH-1:0]   dividend;
  logic signed [sdiv_pkg::WIDTH-1:0]   divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sdiv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdiv_pkg::WIDTH-1:0]   quotient;

  modport source (output valid, output quotient, input ready);
  modport sink (input valid, input quotient, output ready);
endinterface

`default_nettype wire

### rtl/sdiv_pre.sv
// Front stage: operand magnitudes, quotient sign and zero-divisor flag.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_pre (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [sdiv_pkg::WIDTH-1:0] dividend,
  input  wire logic [sdiv_pkg::WIDTH-1:0] divisor,
  output      logic                       valid_r,
  output      sdiv_pkg::sdiv_stage_t      stage_r
);
  import sdiv_pkg::*;

  logic        a_neg;
  logic        b_neg;
  sdiv_stage_t stage_nxt;

  always_comb begin
    a_neg             = dividend[WIDTH-1];
    b_neg             = divisor[WIDTH-1];
    stage_nxt.rem     = '0;
    stage_nxt.quo     = '0;
    stage_nxt.num     = a_neg ? (word_t'(0) - dividend) : dividend;
    stage_nxt.den     = b_neg ? (word_t'(0) - divisor) : divisor;
    stage_nxt.neg     = a_neg ^ b_neg;
    stage_nxt.dz      = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sdiv_step.sv
// One restoring division step: shift in the next dividend bit, compare, subtract.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_step (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  valid_in,
  input  wire sdiv_pkg::sdiv_stage_t stage_in,
  output      logic                  valid_r,
  output      sdiv_pkg::sdiv_stage_t stage_r
);
  import sdiv_pkg::*;

  logic [WIDTH:0] rem_sh;
  logic [WIDTH:0] den_x;
  logic [WIDTH:0] diff;
  logic           ge;
  sdiv_stage_t    stage_nxt;

  always_comb begin
    rem_sh        = {stage_in.rem, stage_in.num[WIDTH-1]};
    den_x         = {1'b0, stage_in.den};
    diff          = rem_sh - den_x;
    ge            = (rem_sh >= den_x);
    stage_nxt     = stage_in;
    stage_nxt.rem = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    stage_nxt.num = {stage_in.num[WIDTH-2:0], 1'b0};
    stage_nxt.quo = {stage_in.quo[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sdiv_post.sv
// Back stage: restore the sign, saturate, and hold the quotient for the sink.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_post (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire sdiv_pkg::sdiv_stage_t      stage_in,
  output      logic                       valid_r,
  output      logic [sdiv_pkg::WIDTH-1:0] quotient_r
);
  import sdiv_pkg::*;

  word_t quotient_nxt;

  always_comb begin
    if (stage_in.dz) begin
      quotient_nxt = MAX_POS;
    end else if (stage_in.neg) begin
      quotient_nxt = word_t'(0) - stage_in.quo;
    end else if (stage_in.quo >= MAX_POS) begin
      quotient_nxt = MAX_POS;
    end else begin
      quotient_nxt = stage_in.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient_r <= quotient_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/signed_restoring_divider_unit.sv
// Signed restoring divider: one front stage, one stage per quotient bit, one back stage.
// Throughput: one item per cycle; the whole pipeline holds while the output item waits.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
// Depends on sdiv_pkg, sdiv_ifs, sdiv_pre, sdiv_step, sdiv_post.
`default_nettype none

module signed_restoring_divider_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdiv_in_if.sink    in_ch,
  sdiv_out_if.source out_ch
);
  import sdiv_pkg::*;

  logic        en;
  logic        out_valid;
  word_t       quotient;
  logic        valid_s [0:WIDTH];
  sdiv_stage_t stage_s [0:WIDTH];

  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid;
  assign out_ch.quotient = quotient;

  sdiv_pre u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_ch.valid),
    .dividend (in_ch.dividend),
    .divisor  (in_ch.divisor),
    .valid_r  (valid_s[0]),
    .stage_r  (stage_s[0])
  );

  for (genvar g = 0; g < WIDTH; g++) begin : g_step
    sdiv_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (valid_s[g]),
      .stage_in (stage_s[g]),
      .valid_r  (valid_s[g+1]),
      .stage_r  (stage_s[g+1])
    );
  end

  sdiv_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_in   (valid_s[WIDTH]),
    .stage_in   (stage_s[WIDTH]),
    .valid_r    (out_valid),
    .quotient_r (quotient)
  );

endmodule

`default_nettype wire

### rtl/sdiv_checker.sv
// Port-level checks for the signed divider, attached to the top level by bind.
// Depends on sdiv_pkg and signed_restoring_divider_unit.
`default_nettype none

module sdiv_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sdiv_pkg::WIDTH-1:0] quotient
);
  import sdiv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("stalled result item changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item visible after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output slot");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result item appeared while pipeline held");

endmodule

bind signed_restoring_divider_unit sdiv_checker u_sdiv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .quotient  (out_ch.quotient)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_restoring_divider_unit: directed and random operand pairs
// are checked against a bit-accurate quotient predictor. Depends on sdiv_pkg, sdiv_ifs and the unit.

module testbench;
  import sdiv_pkg::*;

  localparam word_t MIN_NEG   = {1'b1, {(WIDTH-1){1'b0}}};
  localparam word_t ONE       = 1;
  localparam word_t MINUS_ONE = '1;
  localparam int    CYCLE_LIMIT = 200000;

  typedef struct {
    word_t dividend;
    word_t divisor;
    word_t quotient;
  } division_t;

  logic clk;
  logic rst_n;

  sdiv_in_if  in_ch ();
  sdiv_out_if out_ch ();

  signed_restoring_divider_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  division_t pending_quotients[$];

  int    cycle_count     = 0;
  int    error_count     = 0;
  int    pairs_sent      = 0;
  int    quotients_seen  = 0;
  int    zero_divisors   = 0;
  int    overflow_pairs  = 0;
  int    burst_left      = 0;
  bit    gaps_on         = 1'b1;
  int    max_gap         = 6;
  bit    rx_shuffle      = 1'b1;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [7:0]  rx_phase   = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items outstanding", cycle_count,
               pending_quotients.size());
      $display("FAIL signed_restoring_divider_unit");
      $finish;
    end
  end

  always @(negedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (!rx_shuffle) begin
      stall_mask <= 16'hFFFF;
    end else if (rx_phase == '0) begin
      stall_mask <= 16'($urandom) | 16'h0001;
    end
    out_ch.ready <= stall_mask[rx_phase[3:0]];
  end

  function automatic word_t divide_truncated(word_t a, word_t b);
    word_t          mag_a;
    word_t          mag_b;
    word_t          q;
    logic [WIDTH:0] rem;
    logic           neg_a;
    logic           neg_b;
    if (b == '0) return MAX_POS;
    neg_a = a[WIDTH-1];
    neg_b = b[WIDTH-1];
    mag_a = neg_a ? -a : a;
    mag_b = neg_b ? -b : b;
    rem = '0;
    q = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      rem = {rem[WIDTH-1:0], mag_a[i]};
      if (rem >= {1'b0, mag_b}) begin
        rem = rem - {1'b0, mag_b};
        q[i] = 1'b1;
      end
    end
    if (neg_a != neg_b) return -q;
    if (q >= MAX_POS) return MAX_POS;
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    division_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      quotients_seen++;
      if (pending_quotients.size() == 0) begin
        report_mismatch($sformatf("unexpected quotient %h", out_ch.quotient));
      end else begin
        want = pending_quotients.pop_front();
        if (out_ch.quotient !== want.quotient) begin
          report_mismatch($sformatf("%h / %h gave %h, expected %h", want.dividend,
                                    want.divisor, out_ch.quotient, want.quotient));
        end
      end
    end
  end

  task automatic send_operands(input word_t a, input word_t b);
    division_t entry;
    int        gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(max_gap, 0) : 0;
      burst_left = $urandom_range(12, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= a;
    in_ch.divisor  <= b;
    do @(posedge clk); while (!in_ch.ready);
    entry.dividend = a;
    entry.divisor  = b;
    entry.quotient = divide_truncated(a, b);
    pending_quotients.push_back(entry);
    pairs_sent++;
    if (b == '0) zero_divisors++;
    if (a == MIN_NEG && b == MINUS_ONE) overflow_pairs++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic word_t shaped_operand(input bit allow_zero);
    word_t w;
    case ($urandom_range(7, 0))
      0: w = MIN_NEG;
      1: w = MAX_POS;
      2: w = allow_zero ? word_t'(0) : ONE;
      3: w = $urandom_range(1, 0) ? ONE : MINUS_ONE;
      4: w = word_t'($urandom_range(32, 0)) - word_t'(16);
      5: begin
        w = $urandom;
        w = w >> $urandom_range(WIDTH - 1, 0);
        if ($urandom_range(1, 0)) w = -w;
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic test_special_operands();
    gaps_on = 1'b1;
    rx_shuffle = 1'b1;
    send_operands('0, '0);
    send_operands(MIN_NEG, '0);
    send_operands(MAX_POS, '0);
    send_operands(MINUS_ONE, '0);
    send_operands(MIN_NEG, MINUS_ONE);
    send_operands(MIN_NEG, ONE);
    send_operands(MAX_POS, ONE);
    send_operands(MIN_NEG + 1, MINUS_ONE);
    send_operands(MAX_POS, MINUS_ONE);
    send_operands(MIN_NEG, MIN_NEG);
    send_operands(MAX_POS, MAX_POS);
    send_operands(MIN_NEG, MAX_POS);
    send_operands(MAX_POS, MIN_NEG);
    send_operands(MINUS_ONE, MIN_NEG);
    send_operands(MIN_NEG, word_t'(2));
    send_operands(MIN_NEG, word_t'(-2));
    send_operands(word_t'(7), word_t'(2));
    send_operands(word_t'(-7), word_t'(2));
    send_operands(word_t'(7), word_t'(-2));
    send_operands(word_t'(-7), word_t'(-2));
    send_operands('0, MINUS_ONE);
    send_operands(ONE, MAX_POS);
    send_operands(MAX_POS, word_t'(2));
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_uniform_operands(input int count);
    word_t b;
    gaps_on = 1'b1;
    max_gap = 6;
    rx_shuffle = 1'b1;
    repeat (count) begin
      b = $urandom;
      if ($urandom_range(31, 0) == 0) b = '0;
      send_operands($urandom, b);
    end
  endtask

  task automatic test_pressure_pause(input int count);
    gaps_on = 1'b1;
    max_gap = 3;
    repeat (count) send_operands(shaped_operand(1'b0), shaped_operand(1'b1));
    wait_drain();
    repeat (count) send_operands(shaped_operand(1'b0), shaped_operand(1'b1));
  endtask

  task automatic test_shaped_operands(input int count);
    gaps_on = 1'b1;
    max_gap = 10;
    rx_shuffle = 1'b1;
    repeat (count) send_operands(shaped_operand(1'b1), shaped_operand(1'b1));
  endtask

  task automatic test_full_rate(input int count);
    gaps_on = 1'b0;
    rx_shuffle = 1'b0;
    repeat (count) send_operands($urandom, shaped_operand(1'b1));
    wait_drain();
    rx_shuffle = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    out_ch.ready   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_special_operands();
    test_uniform_operands(300);
    test_pressure_pause(40);
    test_shaped_operands(360);
    test_full_rate(80);
    wait_drain();

    $display("Covered %0d operand pairs: %0d with zero divisor, %0d minimum by minus one",
             pairs_sent, zero_divisors, overflow_pairs);
    $display("Checked %0d quotients, %0d mismatches", quotients_seen, error_count);
    if (error_count == 0 && pending_quotients.size() == 0) begin
      $display("PASS signed_restoring_divider_unit");
    end else begin
      $display("FAIL signed_restoring_divider_unit");
    end
    $finish;
  end

endmodule
